// ----- sv/arsc_pkg.sv -----
// Package for the axial rotary sin/cos generator.
// Holds widths, fixed-point constants, shared types and arithmetic helpers.
// No dependencies.
package arsc_pkg;

  localparam int TOK_W        = 13;
  localparam int PAIR_W       = 7;
  localparam int CFG_W        = 7;
  localparam int LN_W         = 23;
  localparam int OUT_W        = 16;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 32;
  localparam int CFG_IDX_W    = 2;

  localparam int E16_W        = 31;
  localparam int FRONT_STAGES = 46;
  localparam int BACK_STAGES  = 124;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [44:0] OVF_LIMIT = 45'd23072094658;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic signed [34:0] GAIN_Q32 = 35'sd2608131496;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID     = 2'd0,
    REG_QUARTER  = 2'd1,
    REG_PREFIX   = 2'd2,
    REG_LN_THETA = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] grid;
    logic [CFG_W-1:0] quarter;
    logic [CFG_W-1:0] prefix;
    logic [LN_W-1:0]  ln_theta;
  } cfg_t;

  typedef struct packed {
    logic             byp;
    logic [TOK_W-1:0] c;
    logic [E16_W-1:0] e16;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [7:0] div_step(input logic [6:0] rem, input logic nb,
                                          input logic [6:0] d);
    logic [7:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) return {1'b1, 7'(t - {1'b0, d})};
    return {1'b0, t[6:0]};
  endfunction

  // floor((2^32-1)/n) for the Taylor term divisors
  function automatic logic [31:0] recip(input int n);
    case (n)
      1:       return 32'd4294967295;
      2:       return 32'd2147483647;
      3:       return 32'd1431655765;
      4:       return 32'd1073741823;
      5:       return 32'd858993459;
      6:       return 32'd715827882;
      7:       return 32'd613566756;
      8:       return 32'd536870911;
      9:       return 32'd477218588;
      10:      return 32'd429496729;
      11:      return 32'd390451572;
      12:      return 32'd357913941;
      13:      return 32'd330382099;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic signed [32:0] atan_bam(input int i);
    case (i)
      0:       return 33'sd536870912;
      1:       return 33'sd316933406;
      2:       return 33'sd167458907;
      3:       return 33'sd84939220;
      4:       return 33'sd42667331;
      5:       return 33'sd21354465;
      6:       return 33'sd10679838;
      7:       return 33'sd5340245;
      8:       return 33'sd2670163;
      9:       return 33'sd1335087;
      10:      return 33'sd667544;
      11:      return 33'sd333772;
      12:      return 33'sd166886;
      13:      return 33'sd83443;
      14:      return 33'sd41722;
      15:      return 33'sd20861;
      16:      return 33'sd10430;
      17:      return 33'sd5215;
      18:      return 33'sd2608;
      19:      return 33'sd1304;
      20:      return 33'sd652;
      21:      return 33'sd326;
      22:      return 33'sd163;
      23:      return 33'sd81;
      default: return 33'sd0;
    endcase
  endfunction

endpackage

// ----- sv/axial_rope_sin_cos_generator.sv -----
// Axial 2D rotary position embedding sin/cos generator, top level.
// Holds the configuration registers; instantiates arsc_front, arsc_queue
// and arsc_back. Uses arsc_pkg.
//
// One transaction in gives one transaction out, in order, at a sustained rate
// of one per clock while out_tready is high. Each transaction passes through
// 172 registers on its way from input to output: 46 front stages
// (restoring dividers, one bit per stage, for row/column, axis and exponent),
// the four-entry queue, 124 back stages (ln2 reduction, 13 Taylor terms of 4
// stages each, a 39-stage angle divider, 24 CORDIC stages) and the output
// register. The exponential and the angle divider hold most of those registers.
// Write configuration only while no transaction is in flight.
module axial_rope_sin_cos_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [arsc_pkg::IN_TDATA_W-1:0]  in_tdata,  // token_index, pair_index, pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [arsc_pkg::OUT_TDATA_W-1:0] out_tdata, // cos_value, sin_value
  input  logic                             cfg_we,
  input  logic [arsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arsc_pkg::LN_W-1:0]        cfg_wdata
);

  logic [arsc_pkg::CFG_W-1:0] grid_r, quarter_r, prefix_r;
  logic [arsc_pkg::LN_W-1:0]  ln_theta_r;
  arsc_pkg::cfg_t   cfg;
  arsc_pkg::qent_t  push_data, head;
  arsc_pkg::qstat_t qstat;
  logic push, pop;
  logic [arsc_pkg::OUT_W-1:0] cos_v, sin_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r     <= 7'd16;
      quarter_r  <= 7'd16;
      prefix_r   <= 7'd1;
      ln_theta_r <= 23'd301802;
    end else if (cfg_we) begin
      case (arsc_pkg::cfg_reg_t'(cfg_index))
        arsc_pkg::REG_GRID:     grid_r     <= cfg_wdata[6:0];
        arsc_pkg::REG_QUARTER:  quarter_r  <= cfg_wdata[6:0];
        arsc_pkg::REG_PREFIX:   prefix_r   <= cfg_wdata[6:0];
        arsc_pkg::REG_LN_THETA: ln_theta_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // treat zero grid or quarter as one
  always_comb begin
    cfg.grid     = (grid_r == '0) ? 7'd1 : grid_r;
    cfg.quarter  = (quarter_r == '0) ? 7'd1 : quarter_r;
    cfg.prefix   = prefix_r;
    cfg.ln_theta = ln_theta_r;
  end

  arsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .tok       (in_tdata[12:0]),
    .pair      (in_tdata[19:13]),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  arsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  arsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .qhead     (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cos   (cos_v),
    .out_sin   (sin_v)
  );

  assign out_tdata = {sin_v, cos_v};

endmodule

// ----- sv/arsc_front.sv -----
// Front pipeline: accepts transactions, flags prefix tokens, splits the patch
// number into row/column, and computes the Q7.16 exponent. Uses arsc_pkg.
module arsc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  arsc_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [arsc_pkg::TOK_W-1:0]  tok,
  input  logic [arsc_pkg::PAIR_W-1:0] pair,
  output logic                        push,
  output arsc_pkg::qent_t             push_data,
  input  arsc_pkg::qstat_t            qstat
);

  typedef struct packed {
    logic        byp;
    logic [12:0] w1;
    logic [6:0]  r1;
    logic [12:0] w2;
    logic [6:0]  r2;
  } f1_t;

  typedef struct packed {
    logic        byp;
    logic [12:0] c;
    logic [30:0] w;
    logic [6:0]  rem;
  } f2_t;

  f1_t f1_r [0:13];
  f2_t f2_r [0:31];
  f1_t f1_nxt;
  f2_t f2_nxt;
  logic [29:0] prod;
  logic [arsc_pkg::FRONT_STAGES-1:0] fv_r;
  logic en;

  assign en        = !fv_r[arsc_pkg::FRONT_STAGES-1] || !qstat.full;
  assign in_ready  = en;
  assign push      = fv_r[arsc_pkg::FRONT_STAGES-1] && en;
  assign push_data = '{byp: f2_r[31].byp, c: f2_r[31].c, e16: f2_r[31].w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[arsc_pkg::FRONT_STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    f1_nxt.byp = tok < {6'b0, cfg.prefix};
    f1_nxt.w1  = tok - {6'b0, cfg.prefix};
    f1_nxt.r1  = '0;
    f1_nxt.w2  = {6'b0, pair};
    f1_nxt.r2  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r[0] <= f1_nxt;
    end
  end

  for (genvar s = 0; s < 13; s++) begin : g_div1
    logic [7:0] st1, st2;
    f1_t nx;
    always_comb begin
      st1   = arsc_pkg::div_step(f1_r[s].r1, f1_r[s].w1[12], cfg.grid);
      st2   = arsc_pkg::div_step(f1_r[s].r2, f1_r[s].w2[12], cfg.quarter);
      nx    = f1_r[s];
      nx.w1 = {f1_r[s].w1[11:0], st1[7]};
      nx.r1 = st1[6:0];
      nx.w2 = {f1_r[s].w2[11:0], st2[7]};
      nx.r2 = st2[6:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        f1_r[s+1] <= nx;
      end
    end
  end

  // row axis when pair lies below the quarter, column axis otherwise
  always_comb begin
    prod       = cfg.ln_theta * f1_r[13].r2;
    f2_nxt.byp = f1_r[13].byp;
    f2_nxt.c   = (f1_r[13].w2 == '0) ? f1_r[13].w1 : {6'b0, f1_r[13].r1};
    f2_nxt.w   = {1'b0, prod} + {25'b0, cfg.quarter[6:1]};
    f2_nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r[0] <= f2_nxt;
    end
  end

  for (genvar s = 0; s < 31; s++) begin : g_div2
    logic [7:0] st;
    f2_t nx;
    always_comb begin
      st     = arsc_pkg::div_step(f2_r[s].rem, f2_r[s].w[30], cfg.quarter);
      nx     = f2_r[s];
      nx.w   = {f2_r[s].w[29:0], st[7]};
      nx.rem = st[6:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        f2_r[s+1] <= nx;
      end
    end
  end

endmodule

// ----- sv/arsc_queue.sv -----
// Four-entry queue between the front and back pipelines.
// Uses arsc_pkg for the entry and status types.
module arsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  arsc_pkg::qent_t  push_data,
  input  logic             pop,
  output arsc_pkg::qent_t  head,
  output arsc_pkg::qstat_t qstat
);

  arsc_pkg::qent_t mem_r [0:arsc_pkg::QUEUE_DEPTH-1];
  logic [arsc_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [arsc_pkg::QCNT_W-1:0] cnt_r;

  assign head        = mem_r[rp_r];
  assign qstat.full  = cnt_r == arsc_pkg::QCNT_W'(arsc_pkg::QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");
`endif

endmodule

// ----- sv/arsc_back.sv -----
// Back pipeline: exponential, angle scaling, CORDIC and output rounding.
// Uses arsc_pkg; fed from arsc_queue.
module arsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arsc_pkg::cfg_t             cfg,
  input  arsc_pkg::qent_t            qhead,
  input  arsc_pkg::qstat_t           qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [arsc_pkg::OUT_W-1:0] out_cos,
  output logic [arsc_pkg::OUT_W-1:0] out_sin
);

  typedef struct packed {
    logic [34:0] rem;
    logic [4:0]  q;
    logic        ovf;
    logic [13:0] absn;
    logic        neg;
    logic        byp;
  } red_t;

  typedef struct packed {
    logic [30:0]        term;
    logic [30:0]        x;
    logic [30:0]        q0;
    logic [34:0]        back;
    logic signed [31:0] sum;
    logic [29:0]        r;
    logic [4:0]         q;
    logic               ovf;
    logic [13:0]        absn;
    logic               neg;
    logic               byp;
  } tay_t;

  typedef struct packed {
    logic [30:0] freq;
    logic [13:0] absn;
    logic        neg;
    logic        byp;
  } fr_t;

  typedef struct packed {
    logic [38:0] w;
    logic [6:0]  rem;
    logic        neg;
    logic        byp;
  } dv_t;

  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [32:0] z;
    logic               flip;
    logic               byp;
  } cr_t;

  localparam logic signed [32:0] QTURN = 33'sd1073741824;
  localparam logic signed [32:0] HTURN = 33'sd2147483648;

  function automatic logic [15:0] sat_out(input logic signed [35:0] v);
    logic signed [35:0] s;
    s = (v + 36'sd65536) >>> 17;
    if (s > 36'sd32767)  return 16'h7FFF;
    if (s < -36'sd32768) return 16'h8000;
    return s[15:0];
  endfunction

  red_t red_r [0:4];
  tay_t tay_r [0:52];
  fr_t  fr_r;
  dv_t  dv_r [0:39];
  cr_t  cr_r [0:24];
  red_t red_nxt;
  fr_t  fr_nxt;
  dv_t  dv_nxt;
  cr_t  cr_nxt;
  logic [arsc_pkg::BACK_STAGES-1:0] bv_r;
  logic out_vld_r;
  logic [15:0] cos_r, sin_r;
  logic en;
  logic [44:0] e30;
  logic signed [14:0] nsg;
  logic [31:0] su, rnd, fq;
  logic [44:0] mag;
  logic [45:0] xs;
  logic [22:0] qa, a23;
  logic signed [32:0] zz;
  logic signed [35:0] vx, vy;

  assign en        = !out_vld_r || out_ready;
  assign pop       = en && !qstat.empty;
  assign out_valid = out_vld_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      bv_r      <= {bv_r[arsc_pkg::BACK_STAGES-2:0], !qstat.empty};
      out_vld_r <= bv_r[arsc_pkg::BACK_STAGES-1];
    end
  end

  always_comb begin
    e30          = {qhead.e16, 14'b0};
    nsg          = $signed({1'b0, qhead.c, 1'b1}) - $signed({8'b0, cfg.grid});
    red_nxt.rem  = e30[34:0];
    red_nxt.q    = '0;
    red_nxt.ovf  = e30 >= arsc_pkg::OVF_LIMIT;
    red_nxt.neg  = nsg[14];
    red_nxt.absn = nsg[14] ? 14'(-nsg) : nsg[13:0];
    red_nxt.byp  = qhead.byp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r[0] <= red_nxt;
    end
  end

  // range reduction: e = q*ln2 + r, one quotient bit per stage
  for (genvar s = 0; s < 5; s++) begin : g_red
    logic [34:0] lim;
    red_t nx;
    tay_t tn;
    always_comb begin
      lim = {5'b0, arsc_pkg::LN2_Q30} << (4 - s);
      nx  = red_r[s];
      if (red_r[s].rem >= lim) begin
        nx.rem = red_r[s].rem - lim;
        nx.q   = {red_r[s].q[3:0], 1'b1};
      end else begin
        nx.q   = {red_r[s].q[3:0], 1'b0};
      end
      tn.term = arsc_pkg::ONE_Q30;
      tn.x    = '0;
      tn.q0   = '0;
      tn.back = '0;
      tn.sum  = 32'sd1073741824;
      tn.r    = nx.rem[29:0];
      tn.q    = nx.q;
      tn.ovf  = nx.ovf;
      tn.absn = nx.absn;
      tn.neg  = nx.neg;
      tn.byp  = nx.byp;
    end
    if (s < 4) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          red_r[s+1] <= nx;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          tay_r[0] <= tn;
        end
      end
    end
  end

  // Taylor series of exp(-r): four stages per term
  for (genvar n = 1; n <= 13; n++) begin : g_term
    localparam int B = 4 * (n - 1);
    logic [60:0] p1;
    logic [62:0] p2;
    logic [34:0] p3;
    logic [34:0] rm;
    logic [30:0] tn;
    tay_t s1, s2, s3, s4;
    always_comb begin
      p1      = tay_r[B].term * tay_r[B].r;
      p2      = tay_r[B+1].x * arsc_pkg::recip(n);
      p3      = tay_r[B+2].q0 * 4'(n);
      rm      = {4'b0, tay_r[B+3].x} - tay_r[B+3].back;
      tn      = tay_r[B+3].q0 + 31'(rm >= 35'(n));
      s1      = tay_r[B];
      s1.x    = p1[60:30];
      s2      = tay_r[B+1];
      s2.q0   = p2[62:32];
      s3      = tay_r[B+2];
      s3.back = p3;
      s4      = tay_r[B+3];
      s4.term = tn;
      s4.sum  = (n % 2 == 1) ? tay_r[B+3].sum - $signed({1'b0, tn})
                             : tay_r[B+3].sum + $signed({1'b0, tn});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tay_r[B+1] <= s1;
        tay_r[B+2] <= s2;
        tay_r[B+3] <= s3;
        tay_r[B+4] <= s4;
      end
    end
  end

  always_comb begin
    su          = tay_r[52].sum;
    rnd         = (32'd1 << tay_r[52].q) >> 1;
    fq          = (su + rnd) >> tay_r[52].q;
    fr_nxt.freq = tay_r[52].ovf ? '0 : fq[30:0];
    fr_nxt.absn = tay_r[52].absn;
    fr_nxt.neg  = tay_r[52].neg;
    fr_nxt.byp  = tay_r[52].byp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
    end
  end

  always_comb begin
    mag        = fr_r.absn * fr_r.freq;
    xs         = {1'b0, mag} + {33'b0, cfg.grid, 6'b0};
    dv_nxt.w   = xs[45:7];
    dv_nxt.rem = '0;
    dv_nxt.neg = fr_r.neg;
    dv_nxt.byp = fr_r.byp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_nxt;
    end
  end

  for (genvar s = 0; s < 39; s++) begin : g_div3
    logic [7:0] st;
    dv_t nx;
    always_comb begin
      st     = arsc_pkg::div_step(dv_r[s].rem, dv_r[s].w[38], cfg.grid);
      nx     = dv_r[s];
      nx.w   = {dv_r[s].w[37:0], st[7]};
      nx.rem = st[6:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[s+1] <= nx;
      end
    end
  end

  // fold the angle into a quarter turn around zero
  always_comb begin
    qa          = dv_r[39].w[22:0];
    a23         = dv_r[39].neg ? (23'd0 - qa) : qa;
    zz          = $signed({a23[22], a23, 9'b0});
    cr_nxt.flip = 1'b0;
    if (zz > QTURN) begin
      zz          = zz - HTURN;
      cr_nxt.flip = 1'b1;
    end else if (zz < -QTURN) begin
      zz          = zz + HTURN;
      cr_nxt.flip = 1'b1;
    end
    cr_nxt.z   = zz;
    cr_nxt.x   = arsc_pkg::GAIN_Q32;
    cr_nxt.y   = '0;
    cr_nxt.byp = dv_r[39].byp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= cr_nxt;
    end
  end

  for (genvar i = 0; i < 24; i++) begin : g_cordic
    cr_t nx;
    always_comb begin
      nx = cr_r[i];
      if (!cr_r[i].z[32]) begin
        nx.x = cr_r[i].x - (cr_r[i].y >>> i);
        nx.y = cr_r[i].y + (cr_r[i].x >>> i);
        nx.z = cr_r[i].z - arsc_pkg::atan_bam(i);
      end else begin
        nx.x = cr_r[i].x + (cr_r[i].y >>> i);
        nx.y = cr_r[i].y - (cr_r[i].x >>> i);
        nx.z = cr_r[i].z + arsc_pkg::atan_bam(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cr_r[i+1] <= nx;
      end
    end
  end

  always_comb begin
    vx = cr_r[24].flip ? -36'(cr_r[24].x) : 36'(cr_r[24].x);
    vy = cr_r[24].flip ? -36'(cr_r[24].y) : 36'(cr_r[24].y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cr_r[24].byp ? 16'h7FFF : sat_out(vx);
      sin_r <= cr_r[24].byp ? 16'h0000 : sat_out(vy);
    end
  end

endmodule
